// ===== sv/skin_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package skin_pkg;

	localparam int JOINTS_DEF     = 64;
	localparam int QUAT_FRAC_DEF  = 14;

	// Command codes
	localparam logic CMD_JOINT  = 1'b0;
	localparam logic CMD_WEIGHT = 1'b1;

	// Datapath widths: rotation operands and the product accumulator
	localparam int OPND_W = 44;
	localparam int MAC_W  = 64;

	typedef struct packed {
		logic               command;
		logic [5:0]         joint_index;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [15:0] aux_x;
		logic signed [15:0] aux_y;
		logic signed [15:0] aux_z;
		logic signed [15:0] aux_w;
		logic               last_weight;
	} skin_in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} skin_out_t;

	// Saturate a wide value to 48, 32 or 16 bits
	function automatic logic signed [47:0] sat48(input logic signed [MAC_W-1:0] x);
		if (x > MAC_W'(64'sh0000_7FFF_FFFF_FFFF))
			return 48'sh7FFF_FFFF_FFFF;
		else if (x < -MAC_W'(64'sh0000_8000_0000_0000))
			return 48'sh8000_0000_0000;
		else
			return x[47:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [MAC_W-1:0] x);
		if (x > MAC_W'(64'sh0000_0000_7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		else if (x < -MAC_W'(64'sh0000_0000_8000_0000))
			return 32'sh8000_0000;
		else
			return x[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [MAC_W-1:0] x);
		if (x > MAC_W'(64'sh0000_0000_0000_7FFF))
			return 16'sh7FFF;
		else if (x < -MAC_W'(64'sh0000_0000_0000_8000))
			return 16'sh8000;
		else
			return x[15:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/skin_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface skin_in_if import skin_pkg::*; ;
	logic     valid;
	logic     ready;
	skin_in_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/skin_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface skin_out_if import skin_pkg::*; ;
	logic      valid;
	logic      ready;
	skin_out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/skin_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Front end: takes items and holds them in a two-entry queue for the engine
module skin_front import skin_pkg::*; (
	input  wire      clk,
	input  wire      arst_n,
	skin_in_if.sink  item,
	skin_in_if.source head
);
	skin_in_t   ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign item.ready = (cnt_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign head.valid = (cnt_q != 2'd0);
	assign head.data  = ent_q[rd_ptr_q];
	assign pop        = head.valid && head.ready;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= item.data;
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/skin_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Back end: joint table, shared multiply-accumulate sequencer, accumulators
module skin_back import skin_pkg::*; #(
	parameter int JOINTS         = JOINTS_DEF,
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	skin_in_if.sink    head,
	skin_out_if.source result
);
	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [15:0] qw;
		logic signed [15:0] qz;
		logic signed [15:0] qy;
		logic signed [15:0] qx;
	} joint_t;

	typedef enum logic [2:0] {S_IDLE, S_RUN, S_BIAS, S_EMIT} state_t;

	// Round half up at the quaternion scale
	function automatic logic signed [MAC_W-1:0] rnd(input logic signed [MAC_W-1:0] x);
		return (x + (MAC_W'(1) <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
	endfunction

	function automatic logic [1:0] nxt3(input logic [1:0] k);
		return (k == 2'd2) ? 2'd0 : k + 2'd1;
	endfunction

	// Joint index wrapped to the table depth, as a constant lookup
	function automatic logic [JW-1:0] wrap_idx(input logic [5:0] j);
		logic [JW-1:0] r;
		r = '0;
		for (int i = 0; i < 64; i++)
			if (j == 6'(i))
				r = JW'(i % JOINTS);
		return r;
	endfunction

	joint_t                  joint_mem [JOINTS];
	joint_t                  rd_q;
	state_t                  state_q;
	skin_in_t                item_q;
	logic signed [OPND_W-1:0] t_q  [3];
	logic signed [OPND_W-1:0] rv_q [3];
	logic signed [OPND_W-1:0] rn_q [3];
	logic signed [MAC_W-1:0]  m_q;
	logic                    phase_q;
	logic [2:0]              grp_q;
	logic [1:0]              sub_q;
	logic [2:0]              bstep_q;
	logic signed [47:0]      acc_pos_q  [3];
	logic signed [31:0]      acc_norm_q [3];
	logic                    out_valid_q;
	skin_out_t               out_q;

	logic                    pop;
	logic [JW-1:0]           idx;
	logic signed [15:0]      q [4];
	logic signed [31:0]      jp [3];
	logic signed [OPND_W-1:0] u [3];
	logic                    tgrp;
	logic [1:0]              k, ka, kb, asel;
	logic signed [15:0]      opa;
	logic signed [OPND_W-1:0] opb;
	logic                    neg, last_sub;
	logic signed [MAC_W-1:0]  prod, m_next, term;
	logic signed [OPND_W-1:0] rres;

	assign head.ready   = (state_q == S_IDLE);
	assign pop          = head.valid && head.ready;
	assign idx          = wrap_idx(head.data.joint_index);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	assign q[0]  = rd_q.qx;
	assign q[1]  = rd_q.qy;
	assign q[2]  = rd_q.qz;
	assign q[3]  = rd_q.qw;
	assign jp[0] = rd_q.px;
	assign jp[1] = rd_q.py;
	assign jp[2] = rd_q.pz;

	// Vector under rotation: weight offset first, then bind normal
	always_comb begin
		if (phase_q) begin
			u[0] = OPND_W'(item_q.aux_x);
			u[1] = OPND_W'(item_q.aux_y);
			u[2] = OPND_W'(item_q.aux_z);
		end else begin
			u[0] = OPND_W'(item_q.vec_x);
			u[1] = OPND_W'(item_q.vec_y);
			u[2] = OPND_W'(item_q.vec_z);
		end
	end

	// Operand selection; groups 0..2 form t, groups 3..5 form the rotated vector
	always_comb begin
		tgrp     = (grp_q < 3'd3);
		k        = tgrp ? grp_q[1:0] : 2'(grp_q - 3'd3);
		ka       = nxt3(k);
		kb       = nxt3(ka);
		neg      = tgrp ? (sub_q == 2'd1) : (sub_q == 2'd2);
		last_sub = neg;
		if (tgrp) begin
			asel = (sub_q == 2'd0) ? ka : kb;
			opb  = (sub_q == 2'd0) ? u[kb] : u[ka];
		end else begin
			priority if (sub_q == 2'd0) begin
				asel = 2'd3;
				opb  = t_q[k];
			end else if (sub_q == 2'd1) begin
				asel = ka;
				opb  = t_q[kb];
			end else begin
				asel = kb;
				opb  = t_q[ka];
			end
		end
		opa = q[asel];
		if (state_q == S_BIAS) begin
			opa = item_q.aux_w;
			opb = (bstep_q < 3'd3) ? rv_q[bstep_q[1:0]] : rn_q[2'(bstep_q - 3'd3)];
			neg = 1'b0;
		end
		prod   = MAC_W'(opa * opb);
		m_next = ((state_q == S_RUN && sub_q != 2'd0) ? m_q : '0) + (neg ? -prod : prod);
		term   = rnd(prod);
		rres   = u[k] + OPND_W'(rnd(m_next)) + (phase_q ? '0 : OPND_W'(jp[k]));
	end

	// Joint table
	always_ff @(posedge clk) begin
		if (pop && head.data.command == CMD_JOINT)
			joint_mem[idx] <= '{px: head.data.vec_x, py: head.data.vec_y,
				pz: head.data.vec_z, qw: head.data.aux_w, qz: head.data.aux_z,
				qy: head.data.aux_y, qx: head.data.aux_x};
		if (pop)
			rd_q <= joint_mem[idx];
	end

	// Sequencer, accumulators and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			m_q         <= '0;
			phase_q     <= 1'b0;
			grp_q       <= '0;
			sub_q       <= '0;
			bstep_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < 3; i++) begin
				t_q[i]        <= '0;
				rv_q[i]       <= '0;
				rn_q[i]       <= '0;
				acc_pos_q[i]  <= '0;
				acc_norm_q[i] <= '0;
			end
		end else begin
			// the emit state reloads the result register itself
			if (result.valid && result.ready && state_q != S_EMIT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						item_q  <= head.data;
						phase_q <= 1'b0;
						grp_q   <= '0;
						sub_q   <= '0;
						bstep_q <= '0;
						if (head.data.command == CMD_WEIGHT)
							state_q <= S_RUN;
					end
				end
				S_RUN: begin
					m_q <= m_next;
					if (last_sub) begin
						sub_q <= '0;
						if (tgrp)
							t_q[k] <= OPND_W'(rnd(m_next <<< 1));
						else if (phase_q)
							rn_q[k] <= rres;
						else
							rv_q[k] <= rres;
						if (grp_q == 3'd5) begin
							grp_q <= '0;
							if (phase_q)
								state_q <= S_BIAS;
							phase_q <= 1'b1;
						end else begin
							grp_q <= grp_q + 3'd1;
						end
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				S_BIAS: begin
					if (bstep_q < 3'd3)
						acc_pos_q[bstep_q[1:0]] <= sat48(MAC_W'(acc_pos_q[bstep_q[1:0]])
							+ MAC_W'(sat48(term)));
					else
						acc_norm_q[2'(bstep_q - 3'd3)] <= sat32(
							MAC_W'(acc_norm_q[2'(bstep_q - 3'd3)]) + MAC_W'(sat32(term)));
					bstep_q <= bstep_q + 3'd1;
					if (bstep_q == 3'd5)
						state_q <= item_q.last_weight ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q    <= 1'b1;
						out_q.pos_x    <= sat32(MAC_W'(acc_pos_q[0]));
						out_q.pos_y    <= sat32(MAC_W'(acc_pos_q[1]));
						out_q.pos_z    <= sat32(MAC_W'(acc_pos_q[2]));
						out_q.normal_x <= sat16(MAC_W'(acc_norm_q[0]));
						out_q.normal_y <= sat16(MAC_W'(acc_norm_q[1]));
						out_q.normal_z <= sat16(MAC_W'(acc_norm_q[2]));
						for (int i = 0; i < 3; i++) begin
							acc_pos_q[i]  <= '0;
							acc_norm_q[i] <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/skeletal_vertex_skinning.sv =====
// Path of a weight transfer to its vertex result with the engine idle: the queue entry,
// 30 multiply steps for the two rotations, 6 bias steps, 1 result load.
// Throughput: one joint write per cycle while the engine is idle; weight items are taken
// one at a time, and the single shared multiply-accumulate unit sets the weight rate. A
// two-entry queue decouples input.
// Reset: arst_n clears accumulators, queue and result valid; the joint table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module skeletal_vertex_skinning import skin_pkg::*; #(
	parameter int JOINTS         = JOINTS_DEF,
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	skin_in_if.sink    item,
	skin_out_if.source result
);
	skin_in_if q_ch ();

	skin_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.head   (q_ch.source)
	);

	skin_back #(
		.JOINTS         (JOINTS),
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_ch.sink),
		.result (result)
	);
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import skin_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 120;
	localparam int HOLD_CYCLES    = 800;

	typedef longint vec3_t [3];
	typedef longint quat_t [4];

	logic clk;
	logic arst_n;

	skin_in_if  item_if ();
	skin_out_if result_if ();

	skeletal_vertex_skinning i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if.sink),
		.result (result_if.source)
	);

	// clock, 12 ns period
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// shadow of the joint table and blend accumulators
	logic [31:0] jt_pos [3][64];
	logic [15:0] jt_quat [4][64];
	int          written_joints [$];
	longint      blend_pos [3];
	longint      blend_nrm [3];
	skin_out_t   pending_vertices [$];

	int mismatch_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int quiet_cycles;

	function automatic longint round_q14(longint x);
		return (x + 64'sd8192) >>> 14;
	endfunction

	function automatic longint clamp_to(longint x, int bits);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	// v' = v + w*t + q x t, with t = 2 (q x v)
	function automatic vec3_t quat_rotate(quat_t q, vec3_t v);
		vec3_t t;
		vec3_t r;
		t[0] = round_q14(2 * (q[1] * v[2] - q[2] * v[1]));
		t[1] = round_q14(2 * (q[2] * v[0] - q[0] * v[2]));
		t[2] = round_q14(2 * (q[0] * v[1] - q[1] * v[0]));
		r[0] = v[0] + round_q14(q[3] * t[0] + q[1] * t[2] - q[2] * t[1]);
		r[1] = v[1] + round_q14(q[3] * t[1] + q[2] * t[0] - q[0] * t[2]);
		r[2] = v[2] + round_q14(q[3] * t[2] + q[0] * t[1] - q[1] * t[0]);
		return r;
	endfunction

	function automatic void blend_weight(skin_in_t it);
		int     j;
		quat_t  q;
		vec3_t  ofs;
		vec3_t  nrm;
		vec3_t  rp;
		vec3_t  rn;
		longint bias;
		skin_out_t vtx;
		j = int'(it.joint_index);
		if (it.command == CMD_JOINT) begin
			jt_pos[0][j] = it.vec_x;
			jt_pos[1][j] = it.vec_y;
			jt_pos[2][j] = it.vec_z;
			jt_quat[0][j] = it.aux_x;
			jt_quat[1][j] = it.aux_y;
			jt_quat[2][j] = it.aux_z;
			jt_quat[3][j] = it.aux_w;
			return;
		end
		for (int k = 0; k < 4; k++)
			q[k] = longint'($signed(jt_quat[k][j]));
		ofs[0] = longint'(it.vec_x);
		ofs[1] = longint'(it.vec_y);
		ofs[2] = longint'(it.vec_z);
		nrm[0] = longint'(it.aux_x);
		nrm[1] = longint'(it.aux_y);
		nrm[2] = longint'(it.aux_z);
		bias = longint'(it.aux_w);
		rp = quat_rotate(q, ofs);
		rn = quat_rotate(q, nrm);
		for (int k = 0; k < 3; k++) begin
			blend_pos[k] = clamp_to(blend_pos[k] + clamp_to(round_q14(
				(longint'($signed(jt_pos[k][j])) + rp[k]) * bias), 48), 48);
			blend_nrm[k] = clamp_to(blend_nrm[k] + clamp_to(round_q14(rn[k] * bias), 32), 32);
		end
		if (!it.last_weight)
			return;
		vtx.pos_x    = 32'(clamp_to(blend_pos[0], 32));
		vtx.pos_y    = 32'(clamp_to(blend_pos[1], 32));
		vtx.pos_z    = 32'(clamp_to(blend_pos[2], 32));
		vtx.normal_x = 16'(clamp_to(blend_nrm[0], 16));
		vtx.normal_y = 16'(clamp_to(blend_nrm[1], 16));
		vtx.normal_z = 16'(clamp_to(blend_nrm[2], 16));
		pending_vertices.push_back(vtx);
		for (int k = 0; k < 3; k++) begin
			blend_pos[k] = '0;
			blend_nrm[k] = '0;
		end
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// one transfer on the item channel, idle gaps ahead of it
	task automatic send_item(skin_in_t it);
		int gap;
		gap = 0;
		while (gap < 60 && $urandom_range(99) < send_idle_pct)
			gap++;
		@(negedge clk);
		while (gap > 0) begin
			item_if.valid = 1'b0;
			gap--;
			@(negedge clk);
		end
		item_if.valid = 1'b1;
		item_if.data  = it;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		blend_weight(it);
		if (it.command == CMD_JOINT && written_joints.size() < 64) begin
			if (!(int'(it.joint_index) inside {written_joints}))
				written_joints.push_back(int'(it.joint_index));
		end
	endtask

	task automatic finish_sending();
		@(negedge clk);
		item_if.valid = 1'b0;
	endtask

	function automatic skin_in_t make_joint(int j, int unit);
		skin_in_t it;
		it = '0;
		it.command     = CMD_JOINT;
		it.joint_index = 6'(j);
		it.vec_x = $urandom;
		it.vec_y = $urandom;
		it.vec_z = $urandom;
		if (unit != 0) begin
			// roughly unit quaternion: small xyz, large w
			it.aux_x = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			it.aux_y = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			it.aux_z = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
			it.aux_w = 16'($urandom_range(12000, 16384));
		end else begin
			it.aux_x = 16'($urandom);
			it.aux_y = 16'($urandom);
			it.aux_z = 16'($urandom);
			it.aux_w = 16'($urandom);
		end
		it.last_weight = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic skin_in_t make_weight(logic last);
		skin_in_t it;
		it = '0;
		it.command     = CMD_WEIGHT;
		it.joint_index = 6'(written_joints[$urandom_range(written_joints.size() - 1)]);
		if ($urandom_range(3) == 0) begin
			it.vec_x = $urandom;
			it.vec_y = $urandom;
			it.vec_z = $urandom;
		end else begin
			it.vec_x = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			it.vec_y = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			it.vec_z = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
		end
		it.aux_x = 16'($urandom);
		it.aux_y = 16'($urandom);
		it.aux_z = 16'($urandom);
		if ($urandom_range(7) == 0)
			it.aux_w = 16'($urandom);
		else
			it.aux_w = 16'($urandom_range(0, 16384));
		it.last_weight = last;
		return it;
	endfunction

	task automatic send_vertex(int weights);
		for (int w = 0; w < weights; w++)
			send_item(make_weight(w == weights - 1));
	endtask

	// drop valid first so the last item is not taken twice
	task automatic wait_drained();
		finish_sending();
		while (pending_vertices.size() != 0)
			@(posedge clk);
	endtask

	// extremes of every field, identity and sign-flip quaternions
	task automatic test_directed();
		skin_in_t it;
		it = '0;
		it.command = CMD_JOINT;
		it.joint_index = 6'd0;
		it.aux_w = 16'sd16384;
		send_item(it);
		it.joint_index = 6'd63;
		it.vec_x = 32'sh7FFF_FFFF;
		it.vec_y = 32'sh8000_0000;
		it.vec_z = 32'sh0001_0000;
		it.aux_x = 16'sh7FFF;
		it.aux_y = 16'sh8000;
		it.aux_z = 16'sh7FFF;
		it.aux_w = 16'sh8000;
		it.last_weight = 1'b1;   // ignored on a joint write
		send_item(it);
		it.joint_index = 6'd5;
		it.vec_x = 32'sh8000_0000;
		it.vec_y = 32'sh7FFF_FFFF;
		it.vec_z = 32'sh8000_0000;
		it.aux_x = 16'sd0;
		it.aux_y = 16'sd0;
		it.aux_z = 16'sd16384;
		it.aux_w = 16'sd0;
		send_item(it);
		for (int j = 0; j < 3; j++) begin
			it = '0;
			it.command = CMD_WEIGHT;
			it.joint_index = (j == 0) ? 6'd0 : (j == 1) ? 6'd63 : 6'd5;
			it.vec_x = 32'sh7FFF_FFFF;
			it.vec_y = 32'sh8000_0000;
			it.vec_z = 32'sh7FFF_FFFF;
			it.aux_x = 16'sh7FFF;
			it.aux_y = 16'sh8000;
			it.aux_z = 16'sh7FFF;
			it.aux_w = 16'sd16384;
			it.last_weight = 1'b1;
			send_item(it);
			it.aux_w = 16'sh8000;
			it.last_weight = 1'b0;
			send_item(it);
			it.aux_w = 16'sh7FFF;
			send_item(it);
			it.vec_x = '0;
			it.aux_w = 16'sd0;
			it.last_weight = 1'b1;
			send_item(it);
		end
		// long accumulation that saturates the position sum
		it.joint_index = 6'd63;
		it.vec_x = 32'sh7FFF_FFFF;
		it.aux_w = 16'sh7FFF;
		it.last_weight = 1'b0;
		for (int k = 0; k < 6; k++)
			send_item(it);
		it.last_weight = 1'b1;
		send_item(it);
		wait_drained();
	endtask

	task automatic test_random(int sender_pct, int receiver_pct, int items);
		int sent;
		int n;
		send_idle_pct  = sender_pct;
		recv_stall_pct = receiver_pct;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(9) == 0) begin
				send_item(make_joint($urandom_range(63), $urandom_range(3)));
				sent++;
			end else begin
				n = $urandom_range(1, 4);
				send_vertex(n);
				sent += n;
			end
		end
		wait_drained();
	endtask

	// receiver holds off long enough for the input queue to fill
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		hold_request = HOLD_CYCLES;
		for (int k = 0; k < 40; k++)
			send_vertex(1);
		wait_drained();
	endtask

	// receiver ready, with random stalls or a counted hold-off
	always @(negedge clk) begin
		if (hold_request > 0) begin
			result_if.ready <= 1'b0;
			hold_request <= hold_request - 1;
		end else begin
			result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each vertex transfer with the oldest prediction
	always @(posedge clk) begin
		skin_out_t got;
		skin_out_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			got = result_if.data;
			if (pending_vertices.size() == 0) begin
				report_mismatch("unpredicted vertex pos_x", longint'(got.pos_x), 64'sd0);
			end else begin
				want = pending_vertices.pop_front();
				if (got.pos_x !== want.pos_x)
					report_mismatch("pos_x", longint'(got.pos_x), longint'(want.pos_x));
				if (got.pos_y !== want.pos_y)
					report_mismatch("pos_y", longint'(got.pos_y), longint'(want.pos_y));
				if (got.pos_z !== want.pos_z)
					report_mismatch("pos_z", longint'(got.pos_z), longint'(want.pos_z));
				if (got.normal_x !== want.normal_x)
					report_mismatch("normal_x", longint'(got.normal_x),
						longint'(want.normal_x));
				if (got.normal_y !== want.normal_y)
					report_mismatch("normal_y", longint'(got.normal_y),
						longint'(want.normal_y));
				if (got.normal_z !== want.normal_z)
					report_mismatch("normal_z", longint'(got.normal_z),
						longint'(want.normal_z));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		mismatch_count  = 0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_request    = 0;
		quiet_cycles    = 0;
		item_if.valid   = 1'b0;
		item_if.data    = '0;
		result_if.ready = 1'b0;
		for (int k = 0; k < 3; k++) begin
			blend_pos[k] = '0;
			blend_nrm[k] = '0;
		end
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(0, 0, 430);
		test_random(84, 0, 420);
		test_random(0, 84, 420);
		test_random(23, 23, 420);
		test_backpressure();
		finish_sending();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
